/* rtl/core/tltd_pkg.sv */
// Shared types and constants for the text layer tile drawer.
// Holds the request/response words, the controller command and status
// structs and the operation codes. No dependencies.
package tltd_pkg;

   // Default sizes of the tile store and the visible map
   localparam int TILE_COUNT_DEFAULT     = 4096;
   localparam int SCREEN_COLUMNS_DEFAULT = 40;
   localparam int SCREEN_ROWS_DEFAULT    = 28;

   // Palette is 16 banks of 16 colours
   localparam int PAL_AW     = 8;
   localparam int BANK_W     = 4;
   localparam int NIB_W      = 4;
   localparam int MAP_TILE_W = 12;

   // Operation codes
   localparam logic [1:0] OP_WRITE_PALETTE = 2'd0;
   localparam logic [1:0] OP_WRITE_TILE    = 2'd1;
   localparam logic [1:0] OP_WRITE_USAGE   = 2'd2;
   localparam logic [1:0] OP_DRAW          = 2'd3;

   // Request word
   typedef struct packed {
      logic [1:0]  operation;
      logic [14:0] write_index;
      logic [31:0] write_data;
      logic [15:0] map_word;
      logic [5:0]  tile_column;
      logic [4:0]  tile_row;
   } req_type;

   // Response word, one per drawn pixel
   typedef struct packed {
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [15:0] pixel_colour;
      logic        last_pixel;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;
      logic wr_pal;
      logic wr_tile;
      logic wr_usage;
      logic load;
      logic row_read;
      logic pix_step;
      logic flush;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic draw_go;
      logic pix_end;
      logic row_last;
   } sts_type;

endpackage

/* rtl/core/tltd_ctrl.sv */
// Sequencer of the tile drawer: usage clear after reset, write decode,
// and the row/pixel walk of a draw. Uses tltd_pkg types and codes.
module tltd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        operation,
   input  tltd_pkg::sts_type sts,
   output tltd_pkg::cmd_type cmd,
   output logic              busy
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FLAG  = 3'd2;
   localparam logic [2:0] S_PIX   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Decode state into commands and pick the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               case (operation)
                  tltd_pkg::OP_WRITE_PALETTE: cmd.wr_pal   = 1'b1;
                  tltd_pkg::OP_WRITE_TILE:    cmd.wr_tile  = 1'b1;
                  tltd_pkg::OP_WRITE_USAGE:   cmd.wr_usage = 1'b1;
                  tltd_pkg::OP_DRAW: begin
                     cmd.load = 1'b1;
                     state_in = S_FLAG;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FLAG: begin
            if (sts.draw_go) begin
               cmd.row_read = 1'b1;
               state_in     = S_PIX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PIX: begin
            cmd.pix_step = 1'b1;
            if (sts.pix_end && sts.row_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the state; reset enters the usage clear
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/core/tltd_datapath.sv */
// Datapath of the tile drawer: palette, tile row and usage memories,
// row/pixel counters, palette lookup stage and the one-deep pending pixel
// that lets the final pixel be marked. Uses tltd_pkg.
module tltd_datapath #(
   parameter int TILE_COUNT     = tltd_pkg::TILE_COUNT_DEFAULT,
   parameter int SCREEN_COLUMNS = tltd_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = tltd_pkg::SCREEN_ROWS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  tltd_pkg::req_type req,
   input  tltd_pkg::cmd_type cmd,
   output tltd_pkg::sts_type sts,
   output logic              rsp_strobe,
   output tltd_pkg::rsp_type rsp
);

   localparam int TW = $clog2(TILE_COUNT);
   localparam int AW = TW + 3;
   localparam logic [15:0] ROW_DEPTH = 16'(TILE_COUNT * 8);
   localparam logic [12:0] TILE_LIMIT = 13'(TILE_COUNT);
   localparam logic [TW-1:0] CLEAR_END = TW'(TILE_COUNT - 1);

   // Memories
   logic [15:0] pal_mem  [1 << tltd_pkg::PAL_AW];
   logic [31:0] tile_mem [TILE_COUNT * 8];
   logic        usage_mem[TILE_COUNT];

   // Item registers
   logic [TW-1:0]                 tile_ff,  tile_in;
   logic [tltd_pkg::BANK_W-1:0]   bank_ff,  bank_in;
   logic [5:0]                    col_ff,   col_in;
   logic [4:0]                    row_ff,   row_in;
   logic                          range_ff, range_in;
   logic [2:0]                    y_ff,     y_in;
   logic [2:0]                    x_ff,     x_in;
   logic [TW-1:0]                 clr_ff,   clr_in;

   // Memory read data
   logic        usage_rd_ff;
   logic [31:0] row_rd_ff;
   logic [15:0] pal_rd_ff;

   // Lookup stage and pending pixel
   logic        p_valid_ff,    p_valid_in;
   logic [2:0]  p_x_ff,        p_x_in;
   logic [2:0]  p_y_ff,        p_y_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [8:0]  pend_x_ff,     pend_x_in;
   logic [7:0]  pend_y_ff,     pend_y_in;
   logic [15:0] pend_c_ff,     pend_c_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   tltd_pkg::rsp_type rsp_ff,  rsp_in;

   logic [tltd_pkg::MAP_TILE_W-1:0] map_tile;
   logic [tltd_pkg::NIB_W-1:0]      nib;
   logic                            pal_ok, tile_ok, usage_ok;
   logic                            next_row;
   logic [2:0]                      rd_y;
   logic [AW-1:0]                   row_addr;

   assign map_tile = req.map_word[tltd_pkg::MAP_TILE_W-1:0];
   assign pal_ok   = (req.write_index[14:tltd_pkg::PAL_AW] == '0);
   assign tile_ok  = ({1'b0, req.write_index} < ROW_DEPTH);
   assign usage_ok = ({1'b0, req.write_index} < 16'(TILE_COUNT));

   // Select the current pixel nibble and the row to fetch
   assign nib      = row_rd_ff[{x_ff, 2'b00} +: tltd_pkg::NIB_W];
   assign next_row = cmd.pix_step && (x_ff == 3'd7) && (y_ff != 3'd0);
   assign rd_y     = cmd.row_read ? y_ff : (y_ff - 3'd1);
   assign row_addr = {tile_ff, rd_y};

   // Latch a draw item and advance the counters
   always_comb begin
      tile_in  = tile_ff;
      bank_in  = bank_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      range_in = range_ff;
      y_in     = y_ff;
      x_in     = x_ff;
      clr_in   = clr_ff;
      if (cmd.load) begin
         tile_in  = map_tile[TW-1:0];
         bank_in  = req.map_word[15:12];
         col_in   = req.tile_column;
         row_in   = req.tile_row;
         range_in = ({1'b0, req.tile_column} < 7'(SCREEN_COLUMNS))
                 && ({1'b0, req.tile_row} < 6'(SCREEN_ROWS))
                 && ({1'b0, map_tile} < TILE_LIMIT);
         y_in     = 3'd7;
      end
      if (cmd.row_read) begin
         x_in = 3'd0;
      end
      if (cmd.pix_step) begin
         x_in = x_ff + 3'd1;
      end
      if (next_row) begin
         y_in = y_ff - 3'd1;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + TW'(1);
      end
   end

   // Feed the lookup stage and the pending pixel; emit in order
   always_comb begin
      p_valid_in    = cmd.pix_step && (nib != '0);
      p_x_in        = x_ff;
      p_y_in        = y_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_c_in     = pend_c_ff;
      if (p_valid_ff) begin
         pend_valid_in = 1'b1;
         pend_x_in     = {col_ff, p_x_ff};
         pend_y_in     = {row_ff, p_y_ff};
         pend_c_in     = pal_rd_ff;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      rsp_strobe_in       = pend_valid_ff && (p_valid_ff || cmd.flush);
      rsp_in.pixel_x      = pend_x_ff;
      rsp_in.pixel_y      = pend_y_ff;
      rsp_in.pixel_colour = pend_c_ff;
      rsp_in.last_pixel   = cmd.flush;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         p_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         p_valid_ff    <= p_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tile_ff   <= tile_in;
      bank_ff   <= bank_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      range_ff  <= range_in;
      y_ff      <= y_in;
      x_ff      <= x_in;
      p_x_ff    <= p_x_in;
      p_y_ff    <= p_y_in;
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
      pend_c_ff <= pend_c_in;
      rsp_ff    <= rsp_in;
   end

   // Palette memory
   always_ff @(posedge clock) begin
      if (cmd.wr_pal && pal_ok) begin
         pal_mem[req.write_index[tltd_pkg::PAL_AW-1:0]] <= req.write_data[15:0];
      end
      if (p_valid_in) begin
         pal_rd_ff <= pal_mem[{bank_ff, nib}];
      end
   end

   // Tile row memory
   always_ff @(posedge clock) begin
      if (cmd.wr_tile && tile_ok) begin
         tile_mem[req.write_index[AW-1:0]] <= req.write_data;
      end
      if (cmd.row_read || next_row) begin
         row_rd_ff <= tile_mem[row_addr];
      end
   end

   // Usage flag memory, swept to zero after reset
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         usage_mem[clr_ff] <= 1'b0;
      end else if (cmd.wr_usage && usage_ok) begin
         usage_mem[req.write_index[TW-1:0]] <= req.write_data[0];
      end
      if (cmd.load) begin
         usage_rd_ff <= usage_mem[map_tile[TW-1:0]];
      end
   end

   assign sts.clear_last = (clr_ff == CLEAR_END);
   assign sts.draw_go    = range_ff && usage_rd_ff;
   assign sts.pix_end    = (x_ff == 3'd7);
   assign sts.row_last   = (y_ff == 3'd0);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

/* rtl/core/text_layer_tile_drawer_unit.sv */
// Top level of the text layer tile drawer: joins the sequencer and the
// datapath. Depends on tltd_pkg, tltd_ctrl and tltd_datapath.
//
// Use: present a request word on req_item with start high; it is taken
// at a rising edge where busy is low. Palette, tile row and usage writes
// complete at that edge and leave busy low, so one write per cycle.
// A draw raises busy. When the tile is unused, off screen or out of range,
// the draw ends in S_FLAG with the usage read. Otherwise the sequencer walks
// 8 rows of 8 pixels, one pixel per cycle out of the tile row memory, and
// the draw holds busy through the usage read, the pixel steps and the drain
// (S_DRAIN, S_FLUSH) through the palette read and the pending pixel register.
// Each opaque pixel appears on rsp_item for exactly one cycle with
// rsp_strobe high, in row 7 to row 0 order, left to right; the final one
// carries last_pixel and appears in the first cycle in which busy is low
// again. The receiver cannot stall: every strobe is a delivered word.
// Reset clears the usage flags in a pass over all TILE_COUNT entries during
// which busy stays high. Palette and tile rows are undefined until written.
module text_layer_tile_drawer_unit #(
   parameter int TILE_COUNT     = tltd_pkg::TILE_COUNT_DEFAULT,
   parameter int SCREEN_COLUMNS = tltd_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = tltd_pkg::SCREEN_ROWS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tltd_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tltd_pkg::rsp_type rsp_item
);

   tltd_pkg::cmd_type cmd;
   tltd_pkg::sts_type sts;

   // Sequencer
   tltd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Memories and pixel pipeline
   tltd_datapath #(
      .TILE_COUNT     (TILE_COUNT),
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

   // An accepted draw makes busy high in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.operation == tltd_pkg::OP_DRAW)) |=> busy)
      else $error("draw accepted without raising busy");

   // Writes finish at the accepting edge
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.operation != tltd_pkg::OP_DRAW)) |=> !busy)
      else $error("write left the block busy");

   // The marked pixel ends the stream of its draw
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_pixel) |=> !rsp_strobe)
      else $error("pixel emitted right after the last pixel");

   // The sequencer issues at most one command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");

endmodule
